// ===== hw/rtl/m3inv_pkg.sv =====
// shared widths, payload types and constants of the 3x3 adjugate inverse
package m3inv_pkg;

  // fixed-point format of every entry
  localparam int WordBits = 32;
  localparam int FracBits = 16;
  localparam int Lanes    = 9;

  // exact intermediate widths
  localparam int ProdBits  = 2 * WordBits;
  localparam int MinorBits = 2 * WordBits + 1;
  localparam int PartBits  = 2 * WordBits + 1;
  localparam int DetBits   = 3 * WordBits + 3;
  localparam int DenBits   = DetBits + 1;
  localparam int NumBitsA  = 2 * WordBits + 2 * FracBits + 3;
  localparam int NumBitsB  = (NumBitsA > DetBits + 1) ? NumBitsA : DetBits + 1;
  localparam int RemBits   = (NumBitsB > 4 * WordBits + 4) ? NumBitsB : 4 * WordBits + 4;

  // saturation bounds
  localparam logic [WordBits-1:0] SatPos = {1'b0, {(WordBits - 1){1'b1}}};
  localparam logic [WordBits-1:0] SatNeg = {1'b1, {(WordBits - 1){1'b0}}};

  typedef struct packed {
    logic signed [WordBits-1:0] m_col0_row0;
    logic signed [WordBits-1:0] m_col0_row1;
    logic signed [WordBits-1:0] m_col0_row2;
    logic signed [WordBits-1:0] m_col1_row0;
    logic signed [WordBits-1:0] m_col1_row1;
    logic signed [WordBits-1:0] m_col1_row2;
    logic signed [WordBits-1:0] m_col2_row0;
    logic signed [WordBits-1:0] m_col2_row1;
    logic signed [WordBits-1:0] m_col2_row2;
  } in_t;

  typedef struct packed {
    logic signed [WordBits-1:0] inv_col0_row0;
    logic signed [WordBits-1:0] inv_col0_row1;
    logic signed [WordBits-1:0] inv_col0_row2;
    logic signed [WordBits-1:0] inv_col1_row0;
    logic signed [WordBits-1:0] inv_col1_row1;
    logic signed [WordBits-1:0] inv_col1_row2;
    logic signed [WordBits-1:0] inv_col2_row0;
    logic signed [WordBits-1:0] inv_col2_row1;
    logic signed [WordBits-1:0] inv_col2_row2;
    logic                       singular;
    logic                       saturated;
  } out_t;

  // per-item flags that ride along the divider
  typedef struct packed {
    logic [Lanes-1:0] neg;
    logic [Lanes-1:0] sat;
    logic             zero;
  } div_flags_t;

endpackage

// ===== hw/rtl/m3inv_div.sv =====
// nine-lane pipelined restoring divider, one quotient bit per stage
module m3inv_div (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [m3inv_pkg::RemBits-1:0]        num_i [m3inv_pkg::Lanes],
  input  logic [m3inv_pkg::DenBits-1:0]        den_i,
  input  m3inv_pkg::div_flags_t                flags_i,
  output logic [m3inv_pkg::WordBits-1:0]       quo_o [m3inv_pkg::Lanes],
  output m3inv_pkg::div_flags_t                flags_o
);

  localparam int W  = m3inv_pkg::WordBits;
  localparam int RW = m3inv_pkg::RemBits;
  localparam int DW = m3inv_pkg::DenBits;
  localparam int L  = m3inv_pkg::Lanes;

  logic [RW-1:0]         rem_q [W][L];
  logic [W-1:0]          quo_q [W][L];
  logic [DW-1:0]         den_q [W];
  m3inv_pkg::div_flags_t flg_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam int B = W - 1 - k;
    logic [RW-1:0]         rem_in [L];
    logic [W-1:0]          quo_in [L];
    logic [DW-1:0]         den_in;
    m3inv_pkg::div_flags_t flg_in;
    logic [RW-1:0]         dsh;

    // stage inputs come from the ports or the stage before
    if (k == 0) begin : g_first
      for (genvar l = 0; l < L; l++) begin : g_l
        assign rem_in[l] = num_i[l];
        assign quo_in[l] = '0;
      end
      assign den_in = den_i;
      assign flg_in = flags_i;
    end else begin : g_next
      for (genvar l = 0; l < L; l++) begin : g_l
        assign rem_in[l] = rem_q[k-1][l];
        assign quo_in[l] = quo_q[k-1][l];
      end
      assign den_in = den_q[k-1];
      assign flg_in = flg_q[k-1];
    end

    // divisor aligned to this quotient bit
    assign dsh = RW'(den_in) << B;

    // compare and subtract per lane
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < L; l++) begin
          if (rem_in[l] >= dsh) begin
            rem_q[k][l]    <= rem_in[l] - dsh;
            quo_q[k][l]    <= quo_in[l] | (W'(1) << B);
          end else begin
            rem_q[k][l]    <= rem_in[l];
            quo_q[k][l]    <= quo_in[l];
          end
        end
        den_q[k] <= den_in;
        flg_q[k] <= flg_in;
      end
    end
  end

  for (genvar l = 0; l < L; l++) begin : g_out
    assign quo_o[l] = quo_q[W-1][l];
  end
  assign flags_o = flg_q[W-1];

endmodule

// ===== hw/rtl/matrix3_inverse_adjugate.sv =====
// 3x3 inverse by adjugate: one word per cycle while out_ready_i does not stall the pipe.
// eight arithmetic stages (products, minors, split det products, term sums, det sum, magnitudes,
// numerators, range check), then one divider stage per quotient bit, then the output register.
// the whole pipe advances together; it holds while the output word waits for out_ready_i.
// reset clears only the valid bits; the datapath keeps no state between words.
module matrix3_inverse_adjugate (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  m3inv_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output m3inv_pkg::out_t out_data_o
);

  localparam int W   = m3inv_pkg::WordBits;
  localparam int F   = m3inv_pkg::FracBits;
  localparam int L   = m3inv_pkg::Lanes;
  localparam int PB  = m3inv_pkg::ProdBits;
  localparam int MB  = m3inv_pkg::MinorBits;
  localparam int QB  = m3inv_pkg::PartBits;
  localparam int DB  = m3inv_pkg::DetBits;
  localparam int NB  = m3inv_pkg::DenBits;
  localparam int RB  = m3inv_pkg::RemBits;
  localparam int Lat = 9 + W;

  logic adv;
  logic [Lat-1:0] vld_q;

  // one stall for the whole pipe
  assign adv         = ~vld_q[Lat-1] | out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[Lat-1];

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  // entries as [column][row]
  logic signed [W-1:0] ent [3][3];
  assign ent[0][0] = in_data_i.m_col0_row0;
  assign ent[0][1] = in_data_i.m_col0_row1;
  assign ent[0][2] = in_data_i.m_col0_row2;
  assign ent[1][0] = in_data_i.m_col1_row0;
  assign ent[1][1] = in_data_i.m_col1_row1;
  assign ent[1][2] = in_data_i.m_col1_row2;
  assign ent[2][0] = in_data_i.m_col2_row0;
  assign ent[2][1] = in_data_i.m_col2_row1;
  assign ent[2][2] = in_data_i.m_col2_row2;

  logic signed [PB-1:0] pa_q [3][3];
  logic signed [PB-1:0] pb_q [3][3];
  logic signed [W-1:0]  e0_s1_q [3];
  logic signed [W-1:0]  e0_s2_q [3];
  logic signed [MB-1:0] cof_s2_q [3][3];
  logic signed [MB-1:0] cof_s3_q [3][3];
  logic signed [MB-1:0] cof_s4_q [3][3];
  logic signed [MB-1:0] cof_s5_q [3][3];
  logic signed [QB-1:0] plo_q [3];
  logic signed [QB-1:0] phi_q [3];
  logic signed [DB-1:0] term_q [3];
  logic signed [DB-1:0] det_q;

  // stage 1: the two products of every 2x2 minor, indexed [row][col] of the dropped entry
  for (genvar gr = 0; gr < 3; gr++) begin : g_row
    for (genvar gc = 0; gc < 3; gc++) begin : g_col
      localparam int RA = (gr == 0) ? 1 : 0;
      localparam int RR = (gr == 2) ? 1 : 2;
      localparam int CA = (gc == 0) ? 1 : 0;
      localparam int CC = (gc == 2) ? 1 : 2;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          pa_q[gr][gc] <= PB'(ent[CA][RA]) * PB'(ent[CC][RR]);
          pb_q[gr][gc] <= PB'(ent[CC][RA]) * PB'(ent[CA][RR]);
        end
      end
      // stage 2: signed cofactor
      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (((gr + gc) % 2) == 1) begin
            cof_s2_q[gr][gc] <= MB'(pb_q[gr][gc]) - MB'(pa_q[gr][gc]);
          end else begin
            cof_s2_q[gr][gc] <= MB'(pa_q[gr][gc]) - MB'(pb_q[gr][gc]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        e0_s1_q[r] <= ent[0][r];
        e0_s2_q[r] <= e0_s1_q[r];
      end
    end
  end

  // stages 3 to 5: determinant along the first column, the wide product split in two halves
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        plo_q[r]  <= QB'(e0_s2_q[r]) * QB'($signed({1'b0, cof_s2_q[r][0][W-1:0]}));
        phi_q[r]  <= QB'(e0_s2_q[r]) * QB'($signed(cof_s2_q[r][0][MB-1:W]));
        term_q[r] <= (DB'(phi_q[r]) <<< W) + DB'(plo_q[r]);
      end
      det_q    <= term_q[0] + term_q[1] + term_q[2];
      cof_s3_q <= cof_s2_q;
      cof_s4_q <= cof_s3_q;
      cof_s5_q <= cof_s4_q;
    end
  end

  // stage 6: magnitudes and signs
  logic [DB-1:0] dmag_q;
  logic          dneg_q;
  logic          zero_s6_q;
  logic [MB-1:0] nmag_q [L];
  logic [L-1:0]  cneg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dmag_q    <= det_q[DB-1] ? DB'(-det_q) : DB'(det_q);
      dneg_q    <= det_q[DB-1];
      zero_s6_q <= (det_q == '0);
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          nmag_q[3*c+r] <= cof_s5_q[c][r][MB-1] ? MB'(-cof_s5_q[c][r]) : MB'(cof_s5_q[c][r]);
          cneg_q[3*c+r] <= cof_s5_q[c][r][MB-1];
        end
      end
    end
  end

  // stage 7: rounding numerators, divisor and range thresholds
  logic [RB-1:0] num_s7_q [L];
  logic [NB-1:0] den_s7_q;
  logic [RB-1:0] thr_pos_q;
  logic [RB-1:0] thr_neg_q;
  logic [L-1:0]  neg_s7_q;
  logic          zero_s7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < L; l++) begin
        num_s7_q[l] <= (RB'(nmag_q[l]) << (2 * F + 1)) + RB'(dmag_q);
        neg_s7_q[l] <= cneg_q[l] ^ dneg_q;
      end
      den_s7_q  <= NB'(dmag_q) << 1;
      thr_pos_q <= RB'(dmag_q) << W;
      thr_neg_q <= (RB'(dmag_q) << W) + (RB'(dmag_q) << 1);
      zero_s7_q <= zero_s6_q;
    end
  end

  // stage 8: a quotient past the bound saturates
  logic [RB-1:0]         num_s8_q [L];
  logic [NB-1:0]         den_s8_q;
  m3inv_pkg::div_flags_t flg_s8_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < L; l++) begin
        num_s8_q[l]     <= num_s7_q[l];
        flg_s8_q.sat[l] <= num_s7_q[l] >= (neg_s7_q[l] ? thr_neg_q : thr_pos_q);
      end
      flg_s8_q.neg  <= neg_s7_q;
      flg_s8_q.zero <= zero_s7_q;
      den_s8_q      <= den_s7_q;
    end
  end

  // quotient bits, most significant first
  logic [W-1:0]          quo [L];
  m3inv_pkg::div_flags_t flg_dv;

  m3inv_div u_div (
    .clk_i   (clk_i),
    .en_i    (adv),
    .num_i   (num_s8_q),
    .den_i   (den_s8_q),
    .flags_i (flg_s8_q),
    .quo_o   (quo),
    .flags_o (flg_dv)
  );

  // output register: sign, saturation and the singular case
  logic [W-1:0] res [L];
  logic [W-1:0] res_q [L];
  logic         sing_q;
  logic         satf_q;

  always_comb begin
    for (int l = 0; l < L; l++) begin
      if (flg_dv.zero) begin
        res[l] = '0;
      end else if (flg_dv.sat[l]) begin
        res[l] = flg_dv.neg[l] ? m3inv_pkg::SatNeg : m3inv_pkg::SatPos;
      end else begin
        res[l] = flg_dv.neg[l] ? W'(-quo[l]) : quo[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q  <= res;
      sing_q <= flg_dv.zero;
      satf_q <= ~flg_dv.zero & (|flg_dv.sat);
    end
  end

  assign out_data_o.inv_col0_row0 = res_q[0];
  assign out_data_o.inv_col0_row1 = res_q[1];
  assign out_data_o.inv_col0_row2 = res_q[2];
  assign out_data_o.inv_col1_row0 = res_q[3];
  assign out_data_o.inv_col1_row1 = res_q[4];
  assign out_data_o.inv_col1_row2 = res_q[5];
  assign out_data_o.inv_col2_row0 = res_q[6];
  assign out_data_o.inv_col2_row1 = res_q[7];
  assign out_data_o.inv_col2_row2 = res_q[8];
  assign out_data_o.singular      = sing_q;
  assign out_data_o.saturated     = satf_q;

endmodule
